// ----- hdl/lsp_pkg.sv -----
`default_nettype none

package lsp_pkg;

	// operation codes carried on kind
	localparam logic [1:0] KIND_INSERT  = 2'd0;
	localparam logic [1:0] KIND_EXTRACT = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;

	localparam int VALUE_W = 16;
	localparam int PRIO_W  = 8;
	localparam int COUNT_W = 6;

	// one stored queue entry
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]  prio;
	} entry_t;

endpackage

`default_nettype wire

// ----- hdl/linear_scan_priority_queue.sv -----
`default_nettype none

// channel   | handshake            | signals
// ----------+----------------------+---------------------------------------------
// command   | start high, busy low | kind, item_value, item_priority
// result    | done, one cycle      | out_value, found, dropped, entry_count,
//           |                      | is_full, is_empty
//
// insert, clear, unused kind, extract on an empty queue: the result is registered in
// the execute state that follows the word being taken. extract on n entries, winner at
// place w: through the one read port of the entry memory, a scan of all n priorities,
// then a shift of the n - 1 - w later entries down one place.
// asynchronous active-low reset empties the queue; entry contents are not cleared.
// the receiver cannot stall: each result word is shown for one cycle with done.
module linear_scan_priority_queue import lsp_pkg::*; #(
	parameter int QUEUE_DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output      logic               busy,
	input  wire logic [1:0]         kind,
	input  wire logic [VALUE_W-1:0] item_value,
	input  wire logic [PRIO_W-1:0]  item_priority,
	output      logic               done,
	output      logic [VALUE_W-1:0] out_value,
	output      logic               found,
	output      logic               dropped,
	output      logic [COUNT_W-1:0] entry_count,
	output      logic               is_full,
	output      logic               is_empty
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_SHIFT = 2'd3;

	logic [1:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   idx_q;
	logic               pv_q;
	logic [IDX_W-1:0]   pidx_q;
	logic [1:0]         kind_q;
	entry_t             item_q;
	entry_t             rdata_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [PRIO_W-1:0]  best_prio_q;
	logic [VALUE_W-1:0] best_val_q;
	logic               done_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               found_q;
	logic               dropped_q;

	entry_t             mem [QUEUE_DEPTH];
	logic               we;
	logic [IDX_W-1:0]   waddr;
	entry_t             wdata;
	logic [IDX_W-1:0]   raddr;

	logic               upd;
	logic [IDX_W-1:0]   best_idx_nx;
	logic               issue;

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign raddr = idx_q[IDX_W-1:0];
	assign issue = (idx_q < cnt_q);

	// shared comparator: earliest entry wins among equal priorities
	assign upd         = pv_q && ((pidx_q == '0) || (rdata_q.prio > best_prio_q));
	assign best_idx_nx = upd ? pidx_q : best_idx_q;

	// write port: append on insert, move down during the shift
	always_comb begin
		we    = 1'b0;
		waddr = pidx_q - IDX_W'(1);
		wdata = rdata_q;
		unique case (state_q)
			ST_EXEC: begin
				if (kind_q == KIND_INSERT && cnt_q < DEPTH_C) begin
					we    = 1'b1;
					waddr = cnt_q[IDX_W-1:0];
					wdata = item_q;
				end
			end
			ST_SHIFT: begin
				we = pv_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			pv_q        <= 1'b0;
			pidx_q      <= '0;
			kind_q      <= KIND_INSERT;
			item_q      <= '0;
			best_idx_q  <= '0;
			best_prio_q <= '0;
			best_val_q  <= '0;
			done_q      <= 1'b0;
			out_value_q <= '0;
			found_q     <= 1'b0;
			dropped_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q       <= kind;
						item_q.value <= item_value;
						item_q.prio  <= item_priority;
						state_q      <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					out_value_q <= '0;
					found_q     <= 1'b0;
					dropped_q   <= 1'b0;
					idx_q       <= '0;
					pv_q        <= 1'b0;
					unique case (kind_q)
						KIND_INSERT: begin
							if (cnt_q < DEPTH_C) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end else begin
								dropped_q <= 1'b1;
							end
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						KIND_EXTRACT: begin
							if (cnt_q == '0) begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						KIND_CLEAR: begin
							cnt_q   <= '0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SCAN: begin
					if (upd) begin
						best_idx_q  <= pidx_q;
						best_prio_q <= rdata_q.prio;
						best_val_q  <= rdata_q.value;
					end
					if (issue) begin
						pv_q   <= 1'b1;
						pidx_q <= idx_q[IDX_W-1:0];
						idx_q  <= idx_q + CNT_W'(1);
					end else begin
						// last priority compared this cycle
						pv_q    <= 1'b0;
						idx_q   <= CNT_W'(best_idx_nx) + CNT_W'(1);
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (issue) begin
						pv_q   <= 1'b1;
						pidx_q <= idx_q[IDX_W-1:0];
						idx_q  <= idx_q + CNT_W'(1);
					end else begin
						pv_q        <= 1'b0;
						cnt_q       <= cnt_q - CNT_W'(1);
						out_value_q <= best_val_q;
						found_q     <= 1'b1;
						done_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word and status
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign out_value   = out_value_q;
	assign found       = found_q;
	assign dropped     = dropped_q;
	assign entry_count = COUNT_W'(cnt_q);
	assign is_full     = (cnt_q == DEPTH_C);
	assign is_empty    = (cnt_q == '0);

endmodule

`default_nettype wire
